[design/rvex_pkg.sv]
// ============================================================================
// rvex_pkg
// Types, codes and helper functions shared by the RV32IM execute unit.
// ============================================================================
`default_nettype none

package rvex_pkg;

    localparam int NUM_REGS = 32;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [4:0]  SHAMT_MASK  = 5'h1F;
    localparam logic [4:0]  TRAP_REG    = 5'd10;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_WAIT    = 2'd1;
    localparam logic [1:0] ST_EBREAK  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic KIND_EXEC = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic        item_kind;
        logic [31:0] instruction;
        logic [31:0] current_pc;
        logic [31:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] mem_wdata;
        logic        wb_valid;
        logic [4:0]  wb_index;
        logic [31:0] wb_value;
        logic [31:0] trap_value;
    } t_out_item;

    typedef enum logic [1:0] {S_IDLE, S_EX, S_MD, S_FIN} t_state;
    typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_FIX} t_md_state;

    typedef struct packed {
        logic        start;
        logic [2:0]  funct3;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] result;
    } t_md_rsp;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic [31:0] x,
                                        input logic [31:0] y, input logic alt);
        logic [4:0] sh;
        sh = y[4:0] & SHAMT_MASK;
        unique case (f3)
            3'd0: alu = alt ? x - y : x + y;
            3'd1: alu = x << sh;
            3'd2: alu = {31'd0, $signed(x) < $signed(y)};
            3'd3: alu = {31'd0, x < y};
            3'd4: alu = x ^ y;
            3'd5: alu = alt ? 32'($signed(x) >>> sh) : x >> sh;
            3'd6: alu = x | y;
            default: alu = x & y;
        endcase
    endfunction

endpackage

`default_nettype wire

[design/rvex_if.sv]
// ============================================================================
// rvex_in_if / rvex_out_if
// Valid/ready channels carrying input items and result items.
// ============================================================================
`default_nettype none

interface rvex_in_if;
    import rvex_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rvex_out_if;
    import rvex_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/rvex_muldiv.sv]
// ============================================================================
// rvex_muldiv
// Bit-serial multiplier and restoring divider for the M extension.
// ============================================================================
`default_nettype none

module rvex_muldiv (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rvex_pkg::t_md_req i_req,
    output rvex_pkg::t_md_rsp     o_rsp
);
    import rvex_pkg::*;

    t_md_state   r_state, n_state;
    logic [4:0]  r_cnt;
    logic [32:0] r_hi;
    logic [31:0] r_lo;
    logic [31:0] r_mcand;
    logic [31:0] r_a, r_b;
    logic [2:0]  r_f3;
    logic        r_neg, r_done;
    logic [31:0] r_result;

    logic        is_div, sa, sb, na, nb;
    logic [31:0] ma, mb;
    logic [32:0] mul_sum, rem_sh, diff;
    logic [63:0] prod;
    logic [31:0] fix_val;

    // Operand signedness and magnitudes at start.
    always_comb begin
        is_div = i_req.funct3[2];
        sa = (i_req.funct3 == 3'd1) || (i_req.funct3 == 3'd2) || (i_req.funct3 == 3'd4)
             || (i_req.funct3 == 3'd6);
        sb = (i_req.funct3 == 3'd1) || (i_req.funct3 == 3'd4) || (i_req.funct3 == 3'd6);
        na = sa && i_req.a[31];
        nb = sb && i_req.b[31];
        ma = na ? 32'(0 - i_req.a) : i_req.a;
        mb = nb ? 32'(0 - i_req.b) : i_req.b;
    end

    always_comb begin
        mul_sum = r_lo[0] ? r_hi + {1'b0, r_mcand} : r_hi;
        rem_sh  = {r_hi[31:0], r_lo[31]};
        diff    = rem_sh - {1'b0, r_mcand};
        prod    = {r_hi[31:0], r_lo};
        if (r_neg) begin
            prod = 64'(0 - prod);
        end
        if (!r_f3[2]) begin
            fix_val = (r_f3 == 3'd0) ? r_lo : prod[63:32];
        end else if (r_b == 32'd0) begin
            fix_val = r_f3[1] ? r_a : 32'hFFFF_FFFF;
        end else if (r_f3[1]) begin
            fix_val = r_neg ? 32'(0 - r_hi[31:0]) : r_hi[31:0];
        end else begin
            fix_val = r_neg ? 32'(0 - r_lo) : r_lo;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_req.start) begin
                n_state = MD_RUN;
            end
            MD_RUN: if (r_cnt == 5'd31) begin
                n_state = MD_FIX;
            end
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == MD_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MD_IDLE: begin
                r_cnt   <= 5'd0;
                r_f3    <= i_req.funct3;
                r_a     <= i_req.a;
                r_b     <= i_req.b;
                r_hi    <= 33'd0;
                r_lo    <= ma;
                r_mcand <= mb;
                r_neg   <= is_div ? (i_req.funct3[1] ? na : (na ^ nb)) : (na ^ nb);
            end
            MD_RUN: begin
                r_cnt <= r_cnt + 5'd1;
                if (!r_f3[2]) begin
                    {r_hi, r_lo} <= {1'b0, mul_sum, r_lo[31:1]};
                end else if (!diff[32]) begin
                    r_hi <= diff;
                    r_lo <= {r_lo[30:0], 1'b1};
                end else begin
                    r_hi <= rem_sh;
                    r_lo <= {r_lo[30:0], 1'b0};
                end
            end
            default: r_result <= fix_val;
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.busy   = (r_state != MD_IDLE);
    assign o_rsp.result = r_result;

endmodule

`default_nettype wire

[design/rv32im_execute_unit.sv]
// ============================================================================
// rv32im_execute_unit
// Executes one RV32IM instruction or load return per item.
// ============================================================================
// Each input item is either an instruction (with its pc) or the data returned
// for an earlier load. The unit holds the 32 x 32 register file, with x0 tied
// to zero, and returns one result item giving the next pc, the writeback, any
// memory request and a status. An ordinary instruction passes the accepting
// cycle, which reads the register file memory, then the execute state, then
// the finish state, which commits into the result register once the previous
// result has been taken; the next item can be accepted after that. The
// M-extension ops go through a serial multiply/divide unit that retires one
// bit per cycle. Its 32 bit steps are followed by the sign fixup and the
// handoff back to the sequencer. A load reports status waiting and
// the following load-return item writes the extended data into rd; any other
// instruction in between drops the pending load. The register file clears at
// reset through per-entry valid bits, so no clearing pass is needed. A new
// item is accepted while the previous result still waits to be taken.
// ============================================================================
`default_nettype none

module rv32im_execute_unit (
    input wire logic i_clk,
    input wire logic i_rst_n,
    rvex_in_if.sink    i_in,
    rvex_out_if.source o_out
);
    import rvex_pkg::*;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [31:0] r_regs [NUM_REGS];
    logic [NUM_REGS-1:0] r_rvalid;
    logic [31:0] r_rd_a, r_rd_b;
    logic        r_va, r_vb;
    logic        r_pend;
    logic [4:0]  r_pend_dest;
    logic [2:0]  r_pend_kind;
    t_out_item   r_res, r_out;
    logic        r_ovalid;

    logic        accept, is_md, fin;
    logic [4:0]  ra_idx, rb_idx;
    logic [31:0] a, b, inst, pc, npc4, immi, imms, immb, immj, val, ld_val;
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        wb, take;
    t_out_item   ex;
    t_md_req     md_req;
    t_md_rsp     md_rsp;

    assign accept = i_in.valid && i_in.ready;
    assign fin    = (r_state == S_FIN) && (!r_ovalid || o_out.ready);

    always_comb begin
        ra_idx = i_in.data.instruction[19:15];
        rb_idx = (i_in.data.instruction[6:0] == OP_SYSTEM) ? TRAP_REG
                                                            : i_in.data.instruction[24:20];
    end

    // Register file: read at acceptance, written at commit.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a <= r_regs[ra_idx];
            r_rd_b <= r_regs[rb_idx];
            r_va   <= r_rvalid[ra_idx] && (ra_idx != 5'd0) && (int'(ra_idx) < NUM_REGS);
            r_vb   <= r_rvalid[rb_idx] && (rb_idx != 5'd0) && (int'(rb_idx) < NUM_REGS);
            r_item <= i_in.data;
        end
        if (fin && r_res.wb_valid) begin
            r_regs[r_res.wb_index] <= r_res.wb_value;
        end
    end

    always_comb begin
        a    = r_va ? r_rd_a : 32'd0;
        b    = r_vb ? r_rd_b : 32'd0;
        inst = r_item.instruction;
        pc   = r_item.current_pc;
        npc4 = pc + 32'd4;
        op   = inst[6:0];
        rd   = inst[11:7];
        f3   = inst[14:12];
        f7   = inst[31:25];
        immi = {{20{inst[31]}}, inst[31:20]};
        imms = {{20{inst[31]}}, inst[31:25], inst[11:7]};
        immb = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        immj = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
    end

    // Decode and execute everything but the M extension.
    always_comb begin
        ex = '0;
        ex.next_pc = npc4;
        ex.status  = ST_DONE;
        wb     = 1'b0;
        val    = 32'd0;
        take   = 1'b0;
        is_md  = 1'b0;
        ld_val = r_item.load_data;
        if (r_item.item_kind == KIND_LOAD) begin
            unique case (r_pend_kind)
                3'd0: ld_val = {{24{r_item.load_data[7]}}, r_item.load_data[7:0]};
                3'd1: ld_val = {{16{r_item.load_data[15]}}, r_item.load_data[15:0]};
                3'd4: ld_val = {24'd0, r_item.load_data[7:0]};
                3'd5: ld_val = {16'd0, r_item.load_data[15:0]};
                default: ld_val = r_item.load_data;
            endcase
            if (r_pend && r_pend_dest != 5'd0 && int'(r_pend_dest) < NUM_REGS) begin
                ex.wb_valid = 1'b1;
                ex.wb_index = r_pend_dest;
                ex.wb_value = ld_val;
            end
        end else begin
            priority case (op)
                OP_LUI: begin
                    wb = 1'b1;
                    val = {inst[31:12], 12'd0};
                end
                OP_AUIPC: begin
                    wb = 1'b1;
                    val = pc + {inst[31:12], 12'd0};
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 >= 3'd6) begin
                        ex.status = ST_INVALID;
                    end else begin
                        ex.status   = ST_WAIT;
                        ex.mem_op   = MEM_READ;
                        ex.mem_addr = a + immi;
                        ex.mem_size = f3[1:0];
                    end
                end
                OP_STORE: begin
                    if (f3 > 3'd2) begin
                        ex.status = ST_INVALID;
                    end else begin
                        ex.mem_op    = MEM_WRITE;
                        ex.mem_addr  = a + imms;
                        ex.mem_size  = f3[1:0];
                        ex.mem_wdata = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                                       (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                    end
                end
                OP_REG: begin
                    if (f7 == 7'h01) begin
                        wb = 1'b1;
                        is_md = 1'b1;
                    end else if (f7 == 7'h00) begin
                        wb = 1'b1;
                        val = alu(f3, a, b, 1'b0);
                    end else if (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) begin
                        wb = 1'b1;
                        val = alu(f3, a, b, 1'b1);
                    end else begin
                        ex.status = ST_INVALID;
                    end
                end
                OP_IMM: begin
                    if (f3 == 3'd1) begin
                        if (f7 == 7'h00) begin
                            wb = 1'b1;
                            val = alu(f3, a, immi, 1'b0);
                        end else begin
                            ex.status = ST_INVALID;
                        end
                    end else if (f3 == 3'd5) begin
                        if (f7 == 7'h00 || f7 == 7'h20) begin
                            wb = 1'b1;
                            val = alu(f3, a, immi, f7 != 7'h00);
                        end else begin
                            ex.status = ST_INVALID;
                        end
                    end else begin
                        wb = 1'b1;
                        val = alu(f3, a, immi, 1'b0);
                    end
                end
                OP_BRANCH: begin
                    unique case (f3)
                        3'd0: take = (a == b);
                        3'd1: take = (a != b);
                        3'd4: take = $signed(a) < $signed(b);
                        3'd5: take = !($signed(a) < $signed(b));
                        3'd6: take = a < b;
                        3'd7: take = a >= b;
                        default: ex.status = ST_INVALID;
                    endcase
                    if (take) begin
                        ex.next_pc = pc + immb;
                    end
                end
                OP_JAL: begin
                    wb = 1'b1;
                    val = npc4;
                    ex.next_pc = pc + immj;
                end
                OP_JALR: begin
                    if (f3 != 3'd0) begin
                        ex.status = ST_INVALID;
                    end else begin
                        wb = 1'b1;
                        val = npc4;
                        ex.next_pc = (a + immi) & ~32'd1;
                    end
                end
                OP_SYSTEM: begin
                    if (inst == EBREAK_WORD) begin
                        ex.status = ST_EBREAK;
                        ex.trap_value = b;
                    end else begin
                        ex.status = ST_INVALID;
                    end
                end
                default: ex.status = ST_INVALID;
            endcase
            if (wb && ex.status == ST_DONE && rd != 5'd0 && int'(rd) < NUM_REGS) begin
                ex.wb_valid = 1'b1;
                ex.wb_index = rd;
                ex.wb_value = val;
            end
        end
    end

    always_comb begin
        md_req.start  = (r_state == S_EX) && is_md && (r_item.item_kind == KIND_EXEC);
        md_req.funct3 = f3;
        md_req.a      = a;
        md_req.b      = b;
    end

    rvex_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                n_state = S_EX;
            end
            S_EX: n_state = md_req.start ? S_MD : S_FIN;
            S_MD: if (md_rsp.done) begin
                n_state = S_FIN;
            end
            default: if (fin) begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rvalid    <= '0;
            r_pend      <= 1'b0;
            r_pend_dest <= 5'd0;
            r_pend_kind <= 3'd0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EX) begin
                if (r_item.item_kind == KIND_LOAD) begin
                    r_pend <= 1'b0;
                end else begin
                    r_pend <= (ex.status == ST_WAIT);
                    if (ex.status == ST_WAIT) begin
                        r_pend_dest <= rd;
                        r_pend_kind <= f3;
                    end
                end
            end
            if (fin && r_res.wb_valid) begin
                r_rvalid[r_res.wb_index] <= 1'b1;
            end
            if (fin) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EX) begin
            r_res <= ex;
        end
        // A multiply/divide into x0 writes nothing, so its value stays zero.
        if (r_state == S_MD && md_rsp.done && r_res.wb_valid) begin
            r_res.wb_value <= md_rsp.result;
        end
        if (fin) begin
            r_out <= r_res;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // The multiply/divide unit is only started when it is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("muldiv started while busy");

    // x0 is never written.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.wb_valid) |-> (o_out.data.wb_index != 5'd0))
        else $error("writeback to x0");

    // A waiting status always carries a read request and leaves a load pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_res.status == ST_WAIT) |-> (r_res.mem_op == MEM_READ && r_pend))
        else $error("wait status without pending load");

    // A finished multiply/divide only arrives while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_MD))
        else $error("muldiv result out of sequence");

endmodule

`default_nettype wire
